// ===== rtl/ihrf_pkg.sv =====
package ihrf_pkg;

	localparam int WORD_W   = 16;
	localparam int ADDR_W   = 32;
	localparam int IDX_W    = 5;
	localparam int HBYTES_W = 6;
	localparam int CFG_IDX_W = 2;

	localparam logic [3:0]        IP_VERSION    = 4'd4;
	localparam logic [HBYTES_W-1:0] MIN_HDR_BYTES = 6'd20;
	localparam logic [WORD_W-1:0] CSUM_GOOD     = 16'hFFFF;
	localparam logic [IDX_W-1:0]  LEN_WORD      = 5'd1;
	localparam logic [IDX_W-1:0]  DST_HI_WORD   = 5'd8;
	localparam logic [IDX_W-1:0]  DST_LO_WORD   = 5'd9;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LOCAL_ADDR = 2'd0,
		REG_NET_MASK   = 2'd1,
		REG_BCAST_ADDR = 2'd2,
		REG_BOOT_ADDR  = 2'd3
	} cfg_reg_t;

	typedef enum logic [2:0] {
		V_ACCEPT     = 3'd0,
		V_BAD_VER    = 3'd1,
		V_SHORT_HDR  = 3'd2,
		V_BAD_CSUM   = 3'd3,
		V_SHORT_TOT  = 3'd4,
		V_NOT_OURS   = 3'd5
	} verdict_t;

	// ones' complement add with end-around carry
	function automatic logic [WORD_W-1:0] oc_add(input logic [WORD_W-1:0] a,
		input logic [WORD_W-1:0] b);
		logic [WORD_W:0] s;
		logic [WORD_W:0] f;
		s = {1'b0, a} + {1'b0, b};
		f = {1'b0, s[WORD_W-1:0]} + {{WORD_W{1'b0}}, s[WORD_W]};
		return f[WORD_W-1:0];
	endfunction

endpackage

// ===== rtl/ipv4_rx_header_filter_core.sv =====
// Path: a header word that completes a verdict goes through the input register,
// then the result register, which shows its verdict.
// Throughput: one header word per cycle; the input register stalls only while a
// verdict is waiting in the result register and the word in hand would make another.
// Reset: arst_n clears all control state, returns to idle (no header in progress) and
// loads the address registers with local 0, mask 0, broadcast all ones, boot 0.
module ipv4_rx_header_filter_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [ihrf_pkg::WORD_W-1:0]       header_word,
	input  logic                              start_of_header,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [2:0]                        verdict,
	output logic                              accept,
	output logic [ihrf_pkg::HBYTES_W-1:0]     header_bytes,
	output logic [ihrf_pkg::WORD_W-1:0]       total_length,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [ihrf_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [ihrf_pkg::ADDR_W-1:0]       cfg_data
);
	import ihrf_pkg::*;

	logic [ADDR_W-1:0] local_addr_q, net_mask_q, bcast_addr_q, boot_addr_q;

	logic              valid_s1;
	logic [WORD_W-1:0] word_s1;
	logic              sof_s1;

	logic [IDX_W-1:0]  word_index_q, words_expected_q;
	logic [WORD_W-1:0] running_sum_q, length_seen_q;
	logic [ADDR_W-1:0] dest_seen_q;
	logic              collecting_q;

	logic              out_valid_q;
	verdict_t          verdict_q;
	logic [HBYTES_W-1:0] hbytes_q;
	logic [WORD_W-1:0] tlen_q;

	// next-state and result of the word in the input register
	logic [IDX_W-1:0]  word_index_d, words_expected_d;
	logic [WORD_W-1:0] running_sum_d, length_seen_d;
	logic [ADDR_W-1:0] dest_seen_d;
	logic              collecting_d;
	logic              emit;
	verdict_t          verdict_d;
	logic [HBYTES_W-1:0] hbytes_d;
	logic [WORD_W-1:0] tlen_d;

	logic [3:0]        ver;
	logic [3:0]        ihl;
	logic [ADDR_W-1:0] subnet_bcast;
	logic              out_free, adv_s1;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			local_addr_q <= '0;
			net_mask_q   <= '0;
			bcast_addr_q <= '1;
			boot_addr_q  <= '0;
		end else if (cfg_valid) begin
			case (cfg_reg_t'(cfg_index))
				REG_LOCAL_ADDR: local_addr_q <= cfg_data;
				REG_NET_MASK:   net_mask_q   <= cfg_data;
				REG_BCAST_ADDR: bcast_addr_q <= cfg_data;
				REG_BOOT_ADDR:  boot_addr_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign out_free = !out_valid_q || out_ready;
	assign adv_s1   = valid_s1 && (!emit || out_free);
	assign in_ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			word_s1 <= header_word;
			sof_s1  <= start_of_header;
		end
	end

	assign ver          = word_s1[15:12];
	assign ihl          = word_s1[11:8];
	assign subnet_bcast = local_addr_q | ~net_mask_q;

	always_comb begin
		word_index_d     = word_index_q;
		words_expected_d = words_expected_q;
		running_sum_d    = running_sum_q;
		length_seen_d    = length_seen_q;
		dest_seen_d      = dest_seen_q;
		collecting_d     = collecting_q;
		emit             = 1'b0;
		verdict_d        = V_ACCEPT;
		hbytes_d         = {ihl, 2'b00};
		tlen_d           = '0;
		if (sof_s1) begin
			// restart: any header in progress is dropped
			words_expected_d = {ihl, 1'b0};
			running_sum_d    = '0;
			length_seen_d    = '0;
			dest_seen_d      = '0;
			word_index_d     = '0;
			collecting_d     = 1'b0;
			if (ver != IP_VERSION) begin
				emit      = 1'b1;
				verdict_d = V_BAD_VER;
			end else if ({ihl, 2'b00} < MIN_HDR_BYTES) begin
				emit      = 1'b1;
				verdict_d = V_SHORT_HDR;
			end else begin
				running_sum_d = oc_add('0, word_s1);
				word_index_d  = IDX_W'(1);
				collecting_d  = 1'b1;
			end
		end else if (collecting_q) begin
			running_sum_d = oc_add(running_sum_q, word_s1);
			case (word_index_q)
				LEN_WORD:    length_seen_d = word_s1;
				DST_HI_WORD: dest_seen_d   = {word_s1, dest_seen_q[15:0]};
				DST_LO_WORD: dest_seen_d   = {dest_seen_q[31:16], word_s1};
				default: ;
			endcase
			word_index_d = word_index_q + IDX_W'(1);
			if (word_index_d >= words_expected_q) begin
				collecting_d = 1'b0;
				emit         = 1'b1;
				hbytes_d     = {words_expected_q, 1'b0};
				tlen_d       = length_seen_d;
				if (running_sum_d != CSUM_GOOD)
					verdict_d = V_BAD_CSUM;
				else if (length_seen_d < {{(WORD_W-HBYTES_W){1'b0}}, hbytes_d})
					verdict_d = V_SHORT_TOT;
				else if (dest_seen_d != local_addr_q && dest_seen_d != bcast_addr_q &&
				         dest_seen_d != boot_addr_q && dest_seen_d != subnet_bcast)
					verdict_d = V_NOT_OURS;
				else
					verdict_d = V_ACCEPT;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_index_q     <= '0;
			words_expected_q <= '0;
			running_sum_q    <= '0;
			length_seen_q    <= '0;
			dest_seen_q      <= '0;
			collecting_q     <= 1'b0;
		end else if (adv_s1) begin
			word_index_q     <= word_index_d;
			words_expected_q <= words_expected_d;
			running_sum_q    <= running_sum_d;
			length_seen_q    <= length_seen_d;
			dest_seen_q      <= dest_seen_d;
			collecting_q     <= collecting_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= adv_s1 && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && adv_s1 && emit) begin
			verdict_q <= verdict_d;
			hbytes_q  <= hbytes_d;
			tlen_q    <= tlen_d;
		end
	end

	assign out_valid    = out_valid_q;
	assign verdict      = verdict_q;
	assign accept       = (verdict_q == V_ACCEPT);
	assign header_bytes = hbytes_q;
	assign total_length = tlen_q;

	a_stall_only_on_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (out_valid_q && !out_ready && valid_s1))
		else $error("input stalled without a waiting verdict");

	a_early_reject_no_len: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (verdict_q == V_BAD_VER || verdict_q == V_SHORT_HDR))
		|-> (tlen_q == '0))
		else $error("first-word reject carries a total length");

	a_hbytes_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (hbytes_q[1:0] == 2'b00))
		else $error("header byte count not a multiple of four");

	a_collect_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		collecting_q |-> (word_index_q < words_expected_q && word_index_q != '0))
		else $error("word index outside header while collecting");

endmodule

// ===== tb/sv/ihrf_verdict_checker.sv =====
`timescale 1ns / 100ps

module ihrf_verdict_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic                           in_ready,
	input  logic [ihrf_pkg::WORD_W-1:0]    header_word,
	input  logic                           start_of_header,
	input  logic                           out_valid,
	input  logic                           out_ready,
	input  logic [2:0]                     verdict,
	input  logic                           accept,
	input  logic [ihrf_pkg::HBYTES_W-1:0]  header_bytes,
	input  logic [ihrf_pkg::WORD_W-1:0]    total_length,
	input  logic                           cfg_valid,
	input  logic                           cfg_ready,
	input  logic [ihrf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ihrf_pkg::ADDR_W-1:0]    cfg_data,
	output int                             fail_count,
	output int                             verdicts_due
);
	import ihrf_pkg::*;

	typedef struct {
		verdict_t            code;
		logic                pass_up;
		logic [HBYTES_W-1:0] hbytes;
		logic [WORD_W-1:0]   tlen;
	} hdr_verdict_t;

	hdr_verdict_t pending_verdicts[$];

	logic [ADDR_W-1:0] cfg_local;
	logic [ADDR_W-1:0] cfg_mask;
	logic [ADDR_W-1:0] cfg_bcast;
	logic [ADDR_W-1:0] cfg_boot;

	logic [IDX_W-1:0]  word_idx;
	logic [IDX_W-1:0]  words_due;
	logic [WORD_W-1:0] hdr_sum;
	logic [WORD_W-1:0] len_field;
	logic [ADDR_W-1:0] dest_field;
	logic              in_header;

	function automatic logic [WORD_W-1:0] sum_fold(input logic [WORD_W-1:0] a,
		input logic [WORD_W-1:0] b);
		logic [WORD_W:0] t;
		t = {1'b0, a} + {1'b0, b};
		return t[WORD_W-1:0] + {{(WORD_W-1){1'b0}}, t[WORD_W]};
	endfunction

	task automatic post_verdict(input verdict_t code, input logic [HBYTES_W-1:0] hb,
		input logic [WORD_W-1:0] tl);
		hdr_verdict_t e;
		e.code    = code;
		e.pass_up = (code == V_ACCEPT);
		e.hbytes  = hb;
		e.tlen    = tl;
		pending_verdicts.push_back(e);
	endtask

	task automatic track_header_word(input logic [WORD_W-1:0] w, input logic sop);
		logic [HBYTES_W-1:0] hb;
		logic [ADDR_W-1:0]   subnet_bcast;
		verdict_t            code;
		if (sop) begin
			// a new start drops whatever header was in progress
			hb         = {w[11:8], 2'b00};
			in_header  = 1'b0;
			word_idx   = '0;
			words_due  = {w[11:8], 1'b0};
			hdr_sum    = '0;
			len_field  = '0;
			dest_field = '0;
			if (w[15:12] != IP_VERSION) begin
				post_verdict(V_BAD_VER, hb, '0);
			end else if (hb < MIN_HDR_BYTES) begin
				post_verdict(V_SHORT_HDR, hb, '0);
			end else begin
				hdr_sum   = sum_fold('0, w);
				word_idx  = 5'd1;
				in_header = 1'b1;
			end
		end else if (in_header) begin
			hdr_sum = sum_fold(hdr_sum, w);
			case (word_idx)
				LEN_WORD:    len_field = w;
				DST_HI_WORD: dest_field[31:16] = w;
				DST_LO_WORD: dest_field[15:0] = w;
				default: ;
			endcase
			word_idx = word_idx + 5'd1;
			if (word_idx >= words_due) begin
				in_header    = 1'b0;
				hb           = {words_due, 1'b0};
				subnet_bcast = cfg_local | ~cfg_mask;
				if (hdr_sum != CSUM_GOOD)
					code = V_BAD_CSUM;
				else if (len_field < {10'd0, hb})
					code = V_SHORT_TOT;
				else if (dest_field != cfg_local && dest_field != cfg_bcast &&
					dest_field != cfg_boot && dest_field != subnet_bcast)
					code = V_NOT_OURS;
				else
					code = V_ACCEPT;
				post_verdict(code, hb, len_field);
			end
		end
	endtask

	task automatic note_failure(input string what);
		fail_count++;
		if (fail_count <= 10)
			$display("%0t: %s", $realtime, what);
	endtask

	task automatic compare_verdict();
		hdr_verdict_t e;
		if (pending_verdicts.size() == 0) begin
			note_failure($sformatf("unexpected verdict %0d accept %0d bytes %0d total %0d",
				verdict, accept, header_bytes, total_length));
			return;
		end
		e = pending_verdicts.pop_front();
		if (verdict !== e.code)
			note_failure($sformatf("verdict: expected %0d (%s) got %0d",
				e.code, e.code.name(), verdict));
		if (accept !== e.pass_up)
			note_failure($sformatf("accept: expected %0d got %0d", e.pass_up, accept));
		if (header_bytes !== e.hbytes)
			note_failure($sformatf("header_bytes: expected %0d got %0d",
				e.hbytes, header_bytes));
		if (total_length !== e.tlen)
			note_failure($sformatf("total_length: expected %0h got %0h",
				e.tlen, total_length));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_local    = '0;
			cfg_mask     = '0;
			cfg_bcast    = '1;
			cfg_boot     = '0;
			word_idx     = '0;
			words_due    = '0;
			hdr_sum      = '0;
			len_field    = '0;
			dest_field   = '0;
			in_header    = 1'b0;
			fail_count   = 0;
			pending_verdicts.delete();
			verdicts_due = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_LOCAL_ADDR: cfg_local = cfg_data;
					REG_NET_MASK:   cfg_mask  = cfg_data;
					REG_BCAST_ADDR: cfg_bcast = cfg_data;
					REG_BOOT_ADDR:  cfg_boot  = cfg_data;
					default: ;
				endcase
			end
			if (out_valid && out_ready)
				compare_verdict();
			if (in_valid && in_ready)
				track_header_word(header_word, start_of_header);
			verdicts_due = pending_verdicts.size();
		end
	end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
	import ihrf_pkg::*;

	localparam int LONG_HOLD = 120;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	logic [WORD_W-1:0]    header_word;
	logic                 start_of_header;
	logic                 out_valid;
	logic                 out_ready;
	logic [2:0]           verdict;
	logic                 accept;
	logic [HBYTES_W-1:0]  header_bytes;
	logic [WORD_W-1:0]    total_length;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [ADDR_W-1:0]    cfg_data;

	int fail_count;
	int verdicts_due;

	bit calm;
	int hold_req;
	logic [ADDR_W-1:0] reg_val [4];

	ipv4_rx_header_filter_core u_top (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.header_word     (header_word),
		.start_of_header (start_of_header),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.verdict         (verdict),
		.accept          (accept),
		.header_bytes    (header_bytes),
		.total_length    (total_length),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data)
	);

	ihrf_verdict_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.header_word     (header_word),
		.start_of_header (start_of_header),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.verdict         (verdict),
		.accept          (accept),
		.header_bytes    (header_bytes),
		.total_length    (total_length),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.fail_count      (fail_count),
		.verdicts_due    (verdicts_due)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	initial begin
		#4_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// result side: random stall bursts, or one long hold when asked
	initial begin : verdict_sink
		int served;
		served = 0;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_req != served) begin
				served = hold_req;
				out_ready = 1'b0;
				repeat (LONG_HOLD - 1) @(negedge clk);
			end else if (!calm && $urandom_range(0, 9) == 0) begin
				out_ready = 1'b0;
				repeat ($urandom_range(0, 9)) @(negedge clk);
			end else begin
				out_ready = 1'b1;
			end
		end
	end

	task automatic push_word(input logic [WORD_W-1:0] w, input logic sop);
		int gap;
		if (!calm && $urandom_range(0, 7) == 0) begin
			in_valid = 1'b0;
			gap = $urandom_range(1, 10);
			repeat (gap) @(negedge clk);
		end
		in_valid        = 1'b1;
		header_word     = w;
		start_of_header = sop;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	// drain every outstanding verdict, then let the pipeline settle
	task automatic drain_verdicts();
		in_valid = 1'b0;
		while (verdicts_due != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t r, input logic [ADDR_W-1:0] d);
		cfg_valid = 1'b1;
		cfg_index = r;
		cfg_data  = d;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
		reg_val[r] = d;
	endtask

	task automatic load_addresses(input logic [ADDR_W-1:0] loc, input logic [ADDR_W-1:0] mask,
		input logic [ADDR_W-1:0] bcast, input logic [ADDR_W-1:0] boot);
		drain_verdicts();
		write_reg(REG_LOCAL_ADDR, loc);
		write_reg(REG_NET_MASK, mask);
		write_reg(REG_BCAST_ADDR, bcast);
		write_reg(REG_BOOT_ADDR, boot);
	endtask

	// build a header with a valid checksum field (or one bit off) and send its first n words
	task automatic send_header(input int ihl, input bit good_sum, input logic [WORD_W-1:0] tlen,
		input logic [ADDR_W-1:0] dst, input int n);
		logic [WORD_W-1:0] hw [30];
		logic [WORD_W:0]   acc;
		logic [WORD_W-1:0] s;
		for (int i = 0; i < 30; i++)
			hw[i] = WORD_W'($urandom);
		hw[0] = {IP_VERSION, 4'(ihl), hw[0][7:0]};
		hw[1] = tlen;
		hw[5] = '0;
		hw[8] = dst[31:16];
		hw[9] = dst[15:0];
		s = '0;
		for (int i = 0; i < ihl * 2; i++) begin
			acc = {1'b0, s} + {1'b0, hw[i]};
			s = acc[WORD_W-1:0] + {{(WORD_W-1){1'b0}}, acc[WORD_W]};
		end
		hw[5] = ~s;
		if (!good_sum)
			hw[5] = hw[5] ^ (16'h1 << $urandom_range(0, 15));
		for (int i = 0; i < n; i++)
			push_word(hw[i], i == 0);
	endtask

	task automatic run_random(input int quota);
		int done;
		int pick;
		int ihl;
		int hb;
		int n;
		int v;
		logic [WORD_W-1:0] tlen;
		logic [ADDR_W-1:0] dst;
		logic [WORD_W-1:0] w;
		done = 0;
		while (done < quota) begin
			pick = $urandom_range(0, 99);
			if (pick < 75) begin
				ihl = ($urandom_range(0, 4) < 3) ? 5 : $urandom_range(6, 15);
				hb = ihl * 4;
				case ($urandom_range(0, 9))
					0: tlen = WORD_W'($urandom_range(0, hb - 1));
					1: tlen = 16'hFFFF;
					2: tlen = WORD_W'(hb);
					default: tlen = WORD_W'($urandom_range(hb, 1500));
				endcase
				case ($urandom_range(0, 4))
					0: dst = reg_val[REG_LOCAL_ADDR];
					1: dst = reg_val[REG_BCAST_ADDR];
					2: dst = reg_val[REG_BOOT_ADDR];
					3: dst = reg_val[REG_LOCAL_ADDR] | ~reg_val[REG_NET_MASK];
					default: dst = $urandom;
				endcase
				// now and then cut the header short; the next start drops it
				n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, ihl * 2 - 1) : ihl * 2;
				send_header(ihl, $urandom_range(0, 9) != 0, tlen, dst, n);
				done += n;
			end else if (pick < 90) begin
				w = WORD_W'($urandom);
				if ($urandom_range(0, 1)) begin
					v = $urandom_range(0, 14);
					if (v >= 4)
						v++;
					w[15:12] = 4'(v);
				end else begin
					w[15:8] = {IP_VERSION, 4'($urandom_range(0, 4))};
				end
				push_word(w, 1'b1);
				done++;
			end else begin
				repeat ($urandom_range(1, 3)) push_word(WORD_W'($urandom), 1'b0);
			end
		end
		// close the phase on a whole header so the block ends up idle
		send_header(5, 1'b1, 16'd20, reg_val[REG_LOCAL_ADDR], 10);
	endtask

	initial begin
		arst_n          = 1'b0;
		in_valid        = 1'b0;
		header_word     = '0;
		start_of_header = 1'b0;
		cfg_valid       = 1'b0;
		cfg_index       = REG_LOCAL_ADDR;
		cfg_data        = '0;
		calm            = 1'b0;
		hold_req        = 0;
		reg_val[REG_LOCAL_ADDR] = '0;
		reg_val[REG_NET_MASK]   = '0;
		reg_val[REG_BCAST_ADDR] = '1;
		reg_val[REG_BOOT_ADDR]  = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// idle words, bad first words, a dropped header, then a broadcast header
		push_word(16'hFFFF, 1'b0);
		push_word(16'h0000, 1'b0);
		push_word(16'h0000, 1'b1);
		push_word(16'hFFFF, 1'b1);
		push_word(16'h4000, 1'b1);
		push_word(16'h44FF, 1'b1);
		send_header(5, 1'b1, 16'd20, 32'h0, 2);
		send_header(5, 1'b1, 16'hFFFF, 32'hFFFF_FFFF, 10);
		drain_verdicts();

		// hold off the result side while bad-version first words keep coming
		hold_req++;
		repeat (24) push_word({4'h6, 4'($urandom), 8'($urandom)}, 1'b1);

		run_random(170);
		load_addresses($urandom, 32'hFFFF_FF00, 32'hFFFF_FFFF, $urandom);
		run_random(200);
		load_addresses(32'h0, 32'h0, 32'h0, 32'h0);
		run_random(200);
		load_addresses(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		run_random(200);
		load_addresses($urandom, $urandom, $urandom, $urandom);
		run_random(200);
		load_addresses($urandom, 32'h0, $urandom, 32'h0);
		calm = 1'b1;
		run_random(200);

		drain_verdicts();
		repeat (10) @(negedge clk);
		if (fail_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
